### rtl/ffha_pkg.sv
//------------------------------------------------------------------------------
// ffha_pkg
// Shared constants and codes of the first-fit heap allocator.
//------------------------------------------------------------------------------
`default_nettype none

package ffha_pkg;

    localparam int DEF_HEAP_GRANULES     = 4096;
    localparam int DEF_GRANULE_BYTES     = 16;  // power of two
    localparam int DEF_MIN_PAYLOAD_BYTES = 16;
    localparam int DEF_HEADER_BYTES      = 16;

    localparam int HEAP_BYTES_W = 17;
    localparam logic [HEAP_BYTES_W-1:0] HEAP_BYTES_RST = 17'd65536;

    localparam logic FN_ALLOC = 1'b0;
    localparam logic FN_FREE  = 1'b1;

    localparam logic [1:0] ST_ALLOC = 2'd0;
    localparam logic [1:0] ST_OOM   = 2'd1;
    localparam logic [1:0] ST_FREED = 2'd2;

endpackage

`default_nettype wire

### rtl/ffha_ifs.sv
//------------------------------------------------------------------------------
// ffha_ifs
// Valid/ready channels of the allocator: request, response, configuration.
//------------------------------------------------------------------------------
`default_nettype none

interface ffha_req_if;
    logic        valid;
    logic        ready;
    logic        func;
    logic [15:0] request_bytes;
    logic [15:0] payload_address;
    modport source (output valid, func, request_bytes, payload_address, input ready);
    modport sink   (input valid, func, request_bytes, payload_address, output ready);
endinterface

interface ffha_rsp_if;
    logic        valid;
    logic        ready;
    logic [15:0] granted_address;
    logic [1:0]  status;
    modport source (output valid, granted_address, status, input ready);
    modport sink   (input valid, granted_address, status, output ready);
endinterface

interface ffha_cfg_if;
    logic        valid;
    logic        ready;
    logic [16:0] data;
    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

### rtl/ffha_ram.sv
//------------------------------------------------------------------------------
// ffha_ram
// Single-port synchronous RAM with registered read data.
//------------------------------------------------------------------------------
`default_nettype none

module ffha_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end

endmodule

`default_nettype wire

### rtl/first_fit_heap_allocator_unit.sv
//------------------------------------------------------------------------------
// first_fit_heap_allocator_unit
// First-fit allocator over an address-ordered free list with coalescing.
//
// Channels: i_req carries one request beat (func, request_bytes,
// payload_address); o_rsp returns one beat per request (granted_address,
// status); i_cfg writes heap_bytes and re-initializes the heap.
// Block headers and free-list links live in one single-port RAM with registered
// read data; every list step costs one RAM read.
// An allocate walks the free list to the first block that fits, writes the
// split-off remainder and the shortened block when it splits, then relinks
// the predecessor or head; a free walks the free blocks below the freed one and
// coalesces it with the adjacent free blocks. One request is in work at a time.
// Reset and every configuration beat spend one cycle writing the initial
// heap block before requests are taken.
// The response is held in an output register; a stalled receiver holds it
// there and the next request is still taken, finishing into a waiting stage
// until the output register frees.
//------------------------------------------------------------------------------
`default_nettype none

module first_fit_heap_allocator_unit
    import ffha_pkg::*;
#(
    parameter int HEAP_GRANULES     = DEF_HEAP_GRANULES,
    parameter int GRANULE_BYTES     = DEF_GRANULE_BYTES,
    parameter int MIN_PAYLOAD_BYTES = DEF_MIN_PAYLOAD_BYTES,
    parameter int HEADER_BYTES      = DEF_HEADER_BYTES
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    ffha_req_if.sink   i_req,
    ffha_rsp_if.source o_rsp,
    ffha_cfg_if.sink   i_cfg
);

    localparam int AW    = $clog2(HEAP_GRANULES);
    localparam int LW    = AW + 1;
    localparam int EW    = 1 + AW + LW;
    localparam int NW    = 18;
    localparam int GBL   = $clog2(GRANULE_BYTES);
    localparam int GW    = 16 - GBL;
    localparam int HDR_G = (HEADER_BYTES + GRANULE_BYTES - 1) / GRANULE_BYTES;
    localparam int MIN_G = (MIN_PAYLOAD_BYTES + GRANULE_BYTES - 1) / GRANULE_BYTES;

    typedef enum logic [12:0] {
        S_INIT   = 13'b0000000000001,
        S_IDLE   = 13'b0000000000010,
        S_AWALK  = 13'b0000000000100,
        S_ASNB   = 13'b0000000001000,
        S_ASCUR  = 13'b0000000010000,
        S_APREV  = 13'b0000000100000,
        S_FWALK  = 13'b0000001000000,
        S_FRDG   = 13'b0000010000000,
        S_FGLEN  = 13'b0000100000000,
        S_FNEXT  = 13'b0001000000000,
        S_FWG    = 13'b0010000000000,
        S_FPREV  = 13'b0100000000000,
        S_DONE   = 13'b1000000000000
    } t_state;

    t_state r_state, n_state;
    logic [HEAP_BYTES_W-1:0] r_heap_bytes, n_heap_bytes;
    logic [LW-1:0] r_granules, n_granules;
    logic [AW-1:0] r_head, n_head;
    logic          r_head_v, n_head_v;
    logic [AW-1:0] r_cur, n_cur;
    logic          r_have, n_have;
    logic [AW-1:0] r_prev, n_prev;
    logic          r_prev_ok, n_prev_ok;
    logic [LW-1:0] r_prev_len, n_prev_len;
    logic [AW:0]   r_steps, n_steps;
    logic [NW-1:0] r_need, n_need;
    logic [AW-1:0] r_g, n_g;
    logic [LW-1:0] r_glen, n_glen;
    logic [AW-1:0] r_glink, n_glink;
    logic          r_gv, n_gv;
    logic          r_ev, n_ev;
    logic [AW-1:0] r_elnk, n_elnk;
    logic [LW-1:0] r_elen, n_elen;
    logic [15:0]   r_res_addr, n_res_addr;
    logic [1:0]    r_res_st, n_res_st;
    logic          r_out_v, n_out_v;
    logic [15:0]   r_out_addr, n_out_addr;
    logic [1:0]    r_out_st, n_out_st;

    logic          w_we;
    logic [AW-1:0] w_addr;
    logic [EW-1:0] w_wdata, w_rdata;
    logic          w_rv;
    logic [AW-1:0] w_rlnk;
    logic [LW-1:0] w_rlen;

    logic [NW-1:0]  w_req_need;
    logic [16:0]    w_req_max;
    logic [GW-1:0]  w_gfull;
    logic [LW-1:0]  w_rem;
    logic           w_fit, w_split;
    logic [AW+1:0]  w_step1;
    logic [31:0]    w_gaddr;
    logic [LW-1:0]  w_cfg_gran;

    ffha_ram #(.WIDTH(EW), .DEPTH(2 ** AW)) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_addr  (w_addr),
        .i_wdata (w_wdata),
        .o_rdata (w_rdata)
    );

    assign w_rv   = w_rdata[EW-1];
    assign w_rlnk = w_rdata[EW-2 -: AW];
    assign w_rlen = w_rdata[LW-1:0];

    assign w_req_max  = (i_req.request_bytes < 16'(MIN_PAYLOAD_BYTES))
                        ? 17'(MIN_PAYLOAD_BYTES) : {1'b0, i_req.request_bytes};
    assign w_req_need = NW'((w_req_max + 17'(GRANULE_BYTES - 1)) >> GBL) + NW'(HDR_G);
    assign w_gfull    = GW'(i_req.payload_address >> GBL);
    assign w_rem      = w_rlen - r_need[LW-1:0];
    assign w_fit      = NW'(w_rlen) >= r_need;
    assign w_split    = (NW'(w_rlen) > r_need) && (w_rem >= LW'(HDR_G + MIN_G))
                        && ((NW'(r_cur) + r_need) < NW'(r_granules));
    assign w_step1    = (AW+2)'(r_steps) + 1'b1;
    assign w_gaddr    = (32'(r_cur) + 32'(HDR_G)) << GBL;
    assign w_cfg_gran = ((i_cfg.data >> GBL) > HEAP_BYTES_W'(HEAP_GRANULES))
                        ? LW'(HEAP_GRANULES) : LW'(i_cfg.data >> GBL);

    assign i_req.ready     = (r_state == S_IDLE);
    assign i_cfg.ready     = (r_state == S_IDLE);
    assign o_rsp.valid     = r_out_v;
    assign o_rsp.granted_address = r_out_addr;
    assign o_rsp.status    = r_out_st;

    always_comb begin
        n_state = r_state;   n_heap_bytes = r_heap_bytes; n_granules = r_granules;
        n_head = r_head;     n_head_v = r_head_v;   n_cur = r_cur;   n_have = r_have;
        n_prev = r_prev;     n_prev_ok = r_prev_ok; n_prev_len = r_prev_len;
        n_steps = r_steps;   n_need = r_need;       n_g = r_g;       n_glen = r_glen;
        n_glink = r_glink;   n_gv = r_gv;           n_ev = r_ev;     n_elnk = r_elnk;
        n_elen = r_elen;     n_res_addr = r_res_addr; n_res_st = r_res_st;
        n_out_v = r_out_v;   n_out_addr = r_out_addr; n_out_st = r_out_st;
        w_we = 1'b0;  w_addr = r_cur;  w_wdata = '0;

        if (r_out_v && o_rsp.ready) begin
            n_out_v = 1'b0;
        end

        unique case (r_state)
            S_INIT: begin
                w_we     = 1'b1;
                w_addr   = '0;
                w_wdata  = {1'b0, AW'(0), r_granules};
                n_head   = '0;
                n_head_v = (r_granules != '0);
                n_state  = S_IDLE;
            end
            S_IDLE: begin
                if (i_cfg.valid) begin
                    n_heap_bytes = i_cfg.data;
                    n_granules   = w_cfg_gran;
                    n_state      = S_INIT;
                end else if (i_req.valid) begin
                    n_prev_ok  = 1'b0;
                    n_steps    = '0;
                    n_cur      = r_head;
                    n_have     = r_head_v;
                    n_res_addr = '0;
                    if (i_req.func == FN_ALLOC) begin
                        n_need = w_req_need;
                        if (r_head_v && LW'(r_head) < r_granules) begin
                            w_addr  = r_head;
                            n_state = S_AWALK;
                        end else begin
                            n_res_st = ST_OOM;
                            n_state  = S_DONE;
                        end
                    end else begin
                        n_res_st = ST_FREED;
                        if (w_gfull < GW'(HDR_G) ||
                            (17'(w_gfull) - 17'(HDR_G)) >= 17'(r_granules)) begin
                            n_state = S_DONE;
                        end else begin
                            n_g = AW'(w_gfull - GW'(HDR_G));
                            if (r_head_v && LW'(r_head) < r_granules &&
                                r_head < AW'(w_gfull - GW'(HDR_G))) begin
                                w_addr  = r_head;
                                n_state = S_FWALK;
                            end else begin
                                n_state = S_FRDG;
                            end
                        end
                    end
                end
            end
            S_AWALK: begin
                if (w_fit) begin
                    n_ev   = w_rv;
                    n_elnk = w_rlnk;
                    n_elen = w_rlen;
                    n_state = w_split ? S_ASNB : S_APREV;
                end else begin
                    n_prev     = r_cur;
                    n_prev_len = w_rlen;
                    n_prev_ok  = 1'b1;
                    n_cur      = w_rlnk;
                    n_steps    = w_step1[AW:0];
                    if (w_step1 < (AW+2)'(HEAP_GRANULES) && w_rv &&
                        LW'(w_rlnk) < r_granules) begin
                        w_addr = w_rlnk;
                    end else begin
                        n_res_st = ST_OOM;
                        n_state  = S_DONE;
                    end
                end
            end
            S_ASNB: begin
                w_we    = 1'b1;
                w_addr  = AW'(NW'(r_cur) + r_need);
                w_wdata = {r_ev, r_elnk, r_elen - r_need[LW-1:0]};
                n_state = S_ASCUR;
            end
            S_ASCUR: begin
                w_we    = 1'b1;
                w_addr  = r_cur;
                w_wdata = {1'b1, AW'(NW'(r_cur) + r_need), r_need[LW-1:0]};
                n_ev    = 1'b1;
                n_elnk  = AW'(NW'(r_cur) + r_need);
                n_state = S_APREV;
            end
            S_APREV: begin
                if (r_prev_ok) begin
                    w_we    = 1'b1;
                    w_addr  = r_prev;
                    w_wdata = {r_ev, r_elnk, r_prev_len};
                end else begin
                    n_head   = r_elnk;
                    n_head_v = r_ev;
                end
                n_res_addr = w_gaddr[15:0];
                n_res_st   = ST_ALLOC;
                n_state    = S_DONE;
            end
            S_FWALK: begin
                n_prev     = r_cur;
                n_prev_len = w_rlen;
                n_prev_ok  = 1'b1;
                n_have     = w_rv;
                n_cur      = w_rlnk;
                n_steps    = w_step1[AW:0];
                if (w_step1 < (AW+2)'(HEAP_GRANULES) && w_rv &&
                    LW'(w_rlnk) < r_granules && w_rlnk < r_g) begin
                    w_addr = w_rlnk;
                end else begin
                    n_state = S_FRDG;
                end
            end
            S_FRDG: begin
                w_addr  = r_g;
                n_state = S_FGLEN;
            end
            S_FGLEN: begin
                n_glen = w_rlen;
                if (r_have && LW'(r_cur) < r_granules) begin
                    w_addr  = r_cur;
                    n_state = S_FNEXT;
                end else begin
                    n_glink = r_cur;
                    n_gv    = r_have;
                    n_state = S_FWG;
                end
            end
            S_FNEXT: begin
                if ((NW'(r_g) + NW'(r_glen)) == NW'(r_cur)) begin
                    n_glen  = r_glen + w_rlen;
                    n_glink = w_rlnk;
                    n_gv    = w_rv;
                end else begin
                    n_glink = r_cur;
                    n_gv    = r_have;
                end
                n_state = S_FWG;
            end
            S_FWG: begin
                w_we    = 1'b1;
                w_addr  = r_g;
                w_wdata = {r_gv, r_glink, r_glen};
                if (r_prev_ok) begin
                    n_state = S_FPREV;
                end else begin
                    n_head   = r_g;
                    n_head_v = 1'b1;
                    n_state  = S_DONE;
                end
            end
            S_FPREV: begin
                w_we   = 1'b1;
                w_addr = r_prev;
                if ((NW'(r_prev) + NW'(r_prev_len)) == NW'(r_g)) begin
                    w_wdata = {r_gv, r_glink, r_prev_len + r_glen};
                end else begin
                    w_wdata = {1'b1, r_g, r_prev_len};
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_v || o_rsp.ready) begin
                    n_out_v    = 1'b1;
                    n_out_addr = r_res_addr;
                    n_out_st   = r_res_st;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_INIT;
            r_heap_bytes <= HEAP_BYTES_RST;
            r_granules   <= ((HEAP_BYTES_RST >> GBL) > HEAP_BYTES_W'(HEAP_GRANULES))
                            ? LW'(HEAP_GRANULES) : LW'(HEAP_BYTES_RST >> GBL);
            r_head       <= '0;
            r_head_v     <= 1'b0;
            r_prev_ok    <= 1'b0;
            r_steps      <= '0;
            r_out_v      <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_heap_bytes <= n_heap_bytes;
            r_granules   <= n_granules;
            r_head       <= n_head;
            r_head_v     <= n_head_v;
            r_prev_ok    <= n_prev_ok;
            r_steps      <= n_steps;
            r_out_v      <= n_out_v;
        end
        r_cur      <= n_cur;      r_have  <= n_have;   r_prev   <= n_prev;
        r_prev_len <= n_prev_len; r_need  <= n_need;   r_g      <= n_g;
        r_glen     <= n_glen;     r_glink <= n_glink;  r_gv     <= n_gv;
        r_ev       <= n_ev;       r_elnk  <= n_elnk;   r_elen   <= n_elen;
        r_res_addr <= n_res_addr; r_res_st <= n_res_st;
        r_out_addr <= n_out_addr; r_out_st <= n_out_st;
    end

    a_cfg_init: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg.valid && i_cfg.ready) |=> (r_state == S_INIT))
        else $error("configuration beat did not start heap init");

    a_steps_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (AW+2)'(r_steps) <= (AW+2)'(HEAP_GRANULES))
        else $error("list walk exceeded step limit");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_v |-> (r_out_st == ST_ALLOC || r_out_st == ST_OOM || r_out_st == ST_FREED))
        else $error("illegal response status");

    a_nonalloc_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && r_out_st != ST_ALLOC) |-> (r_out_addr == '0))
        else $error("address on non-grant response");

    a_head_in_heap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && r_head_v && r_prev_ok == 1'b0 && $past(r_state == S_INIT))
        |-> (r_head == '0))
        else $error("head not at granule zero after init");

endmodule

`default_nettype wire

### sim/tb_first_fit_heap_allocator_unit.sv
//------------------------------------------------------------------------------
// tb_first_fit_heap_allocator_unit
// Regression of the first-fit heap allocator. A behavioral heap model in the
// bench tracks block lengths and the address-ordered free list, predicts the
// response of every request beat, and a monitor compares each response beat
// with the oldest prediction. Heap sizes are rewritten between phases.
//------------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_first_fit_heap_allocator_unit;
    import ffha_pkg::*;

    localparam int NGRAN = DEF_HEAP_GRANULES;
    localparam int GB    = DEF_GRANULE_BYTES;
    localparam int HDR_G = (DEF_HEADER_BYTES + GB - 1) / GB;
    localparam int MIN_G = (DEF_MIN_PAYLOAD_BYTES + GB - 1) / GB;
    localparam longint LIMIT = 2000000;

    typedef struct packed {
        logic [15:0] addr;
        logic [1:0]  status;
    } t_alloc_rsp;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    ffha_req_if req_if ();
    ffha_rsp_if rsp_if ();
    ffha_cfg_if cfg_if ();

    first_fit_heap_allocator_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if.sink),
        .o_rsp   (rsp_if.source),
        .i_cfg   (cfg_if.sink)
    );

    logic [31:0] blk_len [NGRAN];
    logic [31:0] blk_nxt [NGRAN];
    bit          nxt_ok  [NGRAN];
    logic [31:0] head;
    bit          head_ok;
    logic [31:0] heap_g;
    logic [15:0] live_q [$];
    t_alloc_rsp  pending_q [$];
    int          mismatches = 0;
    longint      cycles = 0;

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic heap_init(input logic [16:0] bytes);
        logic [31:0] g;
        g = bytes / GB;
        if (g > NGRAN) g = NGRAN;
        heap_g = g;
        for (int i = 0; i < NGRAN; i++) begin
            blk_len[i] = 0;
            blk_nxt[i] = 0;
            nxt_ok[i] = 0;
        end
        head = 0;
        head_ok = g > 0;
        if (g > 0) blk_len[0] = g;
    endtask

    function automatic void join_next(input logic [31:0] b);
        logic [31:0] n;
        if (!nxt_ok[b]) return;
        n = blk_nxt[b];
        if (n >= heap_g) return;
        if (b + blk_len[b] == n) begin
            blk_len[b] = blk_len[b] + blk_len[n];
            blk_nxt[b] = blk_nxt[n];
            nxt_ok[b] = nxt_ok[n];
        end
    endfunction

    function automatic t_alloc_rsp predict_heap(input logic fn, input logic [15:0] nbytes,
                                                input logic [15:0] paddr);
        logic [31:0] cur, prv, need, rem, g, nb;
        bit have, prv_ok, hit;
        t_alloc_rsp r;
        cur = head; prv = 0; have = head_ok; prv_ok = 0; hit = 0;
        if (fn == FN_ALLOC) begin
            need = ((nbytes < DEF_MIN_PAYLOAD_BYTES ? DEF_MIN_PAYLOAD_BYTES : nbytes)
                    + GB - 1) / GB + HDR_G;
            for (int s = 0; s < NGRAN && have && cur < heap_g; s++) begin
                if (blk_len[cur] >= need) begin
                    hit = 1;
                    break;
                end
                prv = cur; prv_ok = 1; have = nxt_ok[cur]; cur = blk_nxt[cur];
            end
            if (!hit) return '{16'd0, ST_OOM};
            rem = blk_len[cur] - need;
            if (blk_len[cur] > need && rem >= HDR_G + MIN_G && cur + need < heap_g) begin
                nb = cur + need;
                blk_len[nb] = rem;
                blk_nxt[nb] = blk_nxt[cur];
                nxt_ok[nb] = nxt_ok[cur];
                blk_len[cur] = need;
                blk_nxt[cur] = nb;
                nxt_ok[cur] = 1;
            end
            if (prv_ok) begin
                blk_nxt[prv] = blk_nxt[cur]; nxt_ok[prv] = nxt_ok[cur];
            end else begin
                head = blk_nxt[cur]; head_ok = nxt_ok[cur];
            end
            r.addr = 16'((cur + HDR_G) * GB);
            r.status = ST_ALLOC;
            return r;
        end
        g = paddr / GB;
        if (g < HDR_G || g - HDR_G >= heap_g) return '{16'd0, ST_FREED};
        g = g - HDR_G;
        for (int s = 0; s < NGRAN && have && cur < heap_g && cur < g; s++) begin
            prv = cur; prv_ok = 1; have = nxt_ok[cur]; cur = blk_nxt[cur];
        end
        blk_nxt[g] = cur;
        nxt_ok[g] = have;
        if (prv_ok) begin
            blk_nxt[prv] = g; nxt_ok[prv] = 1;
        end else begin
            head = g; head_ok = 1;
        end
        join_next(g);
        if (prv_ok) join_next(prv);
        return '{16'd0, ST_FREED};
    endfunction

    function automatic int gap_len();
        if ($urandom_range(0, 3) == 0) return 0;
        if ($urandom_range(0, 19) == 0) return $urandom_range(20, 80);
        return $urandom_range(0, 3);
    endfunction

    bit calm = 0;

    // response monitor and receiver stalls
    always @(posedge i_clk) begin
        t_alloc_rsp want;
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
        end else begin
            if (rsp_if.valid && rsp_if.ready) begin
                if (pending_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected beat addr=%0d status=%0d",
                                 rsp_if.granted_address, rsp_if.status);
                end else begin
                    want = pending_q.pop_front();
                    if (want.addr !== rsp_if.granted_address
                        || want.status !== rsp_if.status) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: exp addr=%0d status=%0d got addr=%0d status=%0d",
                                     want.addr, want.status, rsp_if.granted_address,
                                     rsp_if.status);
                    end else if (want.status == ST_ALLOC) begin
                        live_q.push_back(want.addr);
                    end
                end
            end
            rsp_if.ready <= calm ? 1'b1 : (gap_len() == 0);
        end
    end

    // valid stays up after an accepted beat until the next call reloads or drops it, or a drain drops it
    task automatic send_req(input logic fn, input logic [15:0] nbytes,
                            input logic [15:0] paddr);
        int gap;
        gap = calm ? 0 : gap_len();
        if (gap != 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_if.valid <= 1'b1;
        req_if.func <= fn;
        req_if.request_bytes <= nbytes;
        req_if.payload_address <= paddr;
        do @(posedge i_clk); while (!req_if.ready);
        pending_q.push_back(predict_heap(fn, nbytes, paddr));
    endtask

    task automatic drain();
        req_if.valid <= 1'b0;
        while (pending_q.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    task automatic write_heap_size(input logic [16:0] bytes);
        drain();
        live_q.delete();
        cfg_if.valid <= 1'b1;
        cfg_if.data <= bytes;
        do @(posedge i_clk); while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        heap_init(bytes);
    endtask

    task automatic free_random_live();
        int k;
        k = $urandom_range(0, live_q.size() - 1);
        send_req(FN_FREE, 16'($urandom), live_q[k] | 16'($urandom_range(0, GB - 1)));
        live_q.delete(k);
    endtask

    task automatic test_directed();
        send_req(FN_ALLOC, 16'd0, 16'hFFFF);
        send_req(FN_ALLOC, 16'd1, 16'h0000);
        send_req(FN_ALLOC, 16'd17, 16'h0);
        send_req(FN_ALLOC, 16'hFFFF, 16'h0);
        send_req(FN_ALLOC, 16'd4000, 16'h0);
        send_req(FN_FREE, 16'hFFFF, 16'd0);
        send_req(FN_FREE, 16'h0, 16'd8);
        drain();
        while (live_q.size() != 0) free_random_live();
        send_req(FN_ALLOC, 16'd65000, 16'h0);
        write_heap_size(17'd32);
        send_req(FN_ALLOC, 16'd0, 16'h0);
        send_req(FN_ALLOC, 16'd0, 16'h0);
        write_heap_size(17'd15);
        send_req(FN_ALLOC, 16'd0, 16'h0);
        send_req(FN_FREE, 16'd0, 16'd16);
        write_heap_size(17'd95);
        send_req(FN_ALLOC, 16'd20, 16'h0);
        send_req(FN_ALLOC, 16'd16, 16'h0);
        send_req(FN_FREE, 16'd0, 16'd64);
        send_req(FN_FREE, 16'd0, 16'hFFF0);
    endtask

    task automatic test_random(input int n, input logic [16:0] bytes, input int maxreq);
        write_heap_size(bytes);
        for (int i = 0; i < n; i++) begin
            if (i == n / 2) begin
                drain();
                calm = 1;
            end
            if (i == n / 2 + 40) calm = 0;
            if (live_q.size() != 0 && $urandom_range(0, 99) < 40)
                free_random_live();
            else if ($urandom_range(0, 29) == 0)
                send_req(FN_ALLOC, 16'($urandom), 16'($urandom));
            else
                send_req(FN_ALLOC, 16'($urandom_range(0, maxreq)), 16'($urandom));
            if (pending_q.size() > 1) drain();
        end
    endtask

    initial begin
        req_if.valid = 1'b0;
        req_if.func = FN_ALLOC;
        req_if.request_bytes = '0;
        req_if.payload_address = '0;
        cfg_if.valid = 1'b0;
        cfg_if.data = '0;
        heap_init(HEAP_BYTES_RST);
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random(300, 17'd65536, 600);
        test_random(300, 17'd1000, 120);
        test_random(250, 17'd4099, 65535);
        test_random(150, 17'd65535, 9000);
        drain();
        if (mismatches == 0 && pending_q.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
